@@ hdl/swc_pkg.sv @@
// shared types, constants and helpers of the segment window clipper
package swc_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int EXT_W       = COORD_WIDTH + 2;
  localparam int LATENCY     = DIFF_W + 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  localparam logic [3:0] REG_INSIDE     = 4'd0;
  localparam logic [3:0] REG_UP         = 4'd1;
  localparam logic [3:0] REG_DOWN       = 4'd2;
  localparam logic [3:0] REG_LEFT       = 4'd3;
  localparam logic [3:0] REG_RIGHT      = 4'd4;
  localparam logic [3:0] REG_UP_LEFT    = 4'd5;
  localparam logic [3:0] REG_UP_RIGHT   = 4'd6;
  localparam logic [3:0] REG_DOWN_LEFT  = 4'd7;
  localparam logic [3:0] REG_DOWN_RIGHT = 4'd8;

  localparam logic [1:0] CFG_LEFT   = 2'd0;
  localparam logic [1:0] CFG_RIGHT  = 2'd1;
  localparam logic [1:0] CFG_BOTTOM = 2'd2;
  localparam logic [1:0] CFG_TOP    = 2'd3;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } seg_in_t;

  typedef struct packed {
    logic       visible;
    coord_t     clip_start_x;
    coord_t     clip_start_y;
    coord_t     clip_end_x;
    coord_t     clip_end_y;
    logic [3:0] start_region;
    logic [3:0] end_region;
  } seg_out_t;

  // one step of the divider chain
  typedef struct packed {
    logic [PROD_W-1:0] rem;
    logic [DIFF_W-1:0] den;
    logic [DIFF_W-1:0] quot;
  } div_stage_t;

  function automatic logic [3:0] region_code(coord_t x, coord_t y, coord_t l, coord_t r,
                                             coord_t b, coord_t t);
    logic [3:0] code;
    if (x > l && x < r && y > b && y < t) code = REG_INSIDE;
    else if (x <= l && y >= t)            code = REG_UP_LEFT;
    else if (x >= r && y >= t)            code = REG_UP_RIGHT;
    else if (x <= l && y <= b)            code = REG_DOWN_LEFT;
    else if (x >= r && y <= b)            code = REG_DOWN_RIGHT;
    else if (y >= t)                      code = REG_UP;
    else if (y <= b)                      code = REG_DOWN;
    else if (x >= r)                      code = REG_RIGHT;
    else                                  code = REG_LEFT;
    return code;
  endfunction

  function automatic logic [DIFF_W-1:0] mag(logic signed [DIFF_W-1:0] v);
    logic [DIFF_W-1:0] m;
    m = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    return m;
  endfunction

endpackage

@@ hdl/swc_div_cell.sv @@
// one restoring division cell, settles one quotient bit per cycle
module swc_div_cell #(
  parameter int STEP = 0
) (
  input  logic               clk,
  input  swc_pkg::div_stage_t d_i,
  output swc_pkg::div_stage_t d_o
);
  import swc_pkg::*;

  logic [PROD_W-1:0] dsh;
  div_stage_t        d_nxt;
  div_stage_t        d_r;

  always_comb begin
    dsh   = PROD_W'(d_i.den) << STEP;
    d_nxt = d_i;
    if (d_i.rem >= dsh) begin
      d_nxt.rem        = d_i.rem - dsh;
      d_nxt.quot[STEP] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign d_o = d_r;

endmodule

@@ hdl/swc_divider.sv @@
// chain of division cells, msb quotient bit first
module swc_divider (
  input  logic               clk,
  input  swc_pkg::div_stage_t d_i,
  output swc_pkg::div_stage_t d_o
);
  import swc_pkg::*;

  div_stage_t link [DIFF_W+1];

  assign link[0] = d_i;

  for (genvar i = 0; i < DIFF_W; i++) begin : g_cell
    swc_div_cell #(.STEP(DIFF_W - 1 - i)) u_cell (
      .clk (clk),
      .d_i (link[i]),
      .d_o (link[i+1])
    );
  end

  assign d_o = link[DIFF_W];

endmodule

@@ hdl/segment_window_clipper.sv @@
// top level of the segment window clipper
//
// Clips one segment per transaction against the window in the four
// configuration registers. A new segment may be started in every cycle:
// busy stays low, and the result of each transaction appears on out_item
// with out_strobe high for exactly one cycle. Results come out in order
// and the receiver cannot stall them. The path runs through the input
// register, one multiply stage, the division chain (one cell per quotient
// bit, COORD_WIDTH + 1 cells) and the output register. Configuration is
// to be written by the user only while no transaction is in flight; the
// block itself does not enforce it.
module segment_window_clipper (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  swc_pkg::seg_in_t           in_item,
  output logic                       out_strobe,
  output swc_pkg::seg_out_t          out_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  swc_pkg::coord_t            cfg_data
);
  import swc_pkg::*;

  // data that travels beside the division chain
  typedef struct packed {
    seg_in_t    seg;
    logic [3:0] reg_s;
    logic [3:0] reg_e;
    logic [3:0] en;
    logic [3:0] erange;
    logic [3:0] neg;
    coord_t     ve_s;
    coord_t     he_s;
    coord_t     ve_e;
    coord_t     he_e;
  } side_t;

  // window registers
  coord_t win_left_r, win_right_r, win_bottom_r, win_top_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r   <= COORD_WIDTH'(0);
      win_right_r  <= COORD_WIDTH'(639);
      win_bottom_r <= COORD_WIDTH'(0);
      win_top_r    <= COORD_WIDTH'(479);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LEFT:   win_left_r   <= cfg_data;
        CFG_RIGHT:  win_right_r  <= cfg_data;
        CFG_BOTTOM: win_bottom_r <= cfg_data;
        default:    win_top_r    <= cfg_data;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  // stage 1: input register
  seg_in_t in_r;
  logic    v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start;
    in_r <= in_item;
  end

  // stage 2: region codes, edge choice, product and divisor
  logic [3:0]  rg [2];
  logic [1:0]  has_v, has_h;
  coord_t      ve [2];
  coord_t      he [2];
  side_t       side_nxt;
  div_stage_t  div_nxt [4];

  always_comb begin
    rg[0] = region_code(in_r.start_x, in_r.start_y, win_left_r, win_right_r,
                        win_bottom_r, win_top_r);
    rg[1] = region_code(in_r.end_x, in_r.end_y, win_left_r, win_right_r,
                        win_bottom_r, win_top_r);
    for (int p = 0; p < 2; p++) begin
      has_v[p] = 1'b0;
      has_h[p] = 1'b0;
      ve[p]    = win_left_r;
      he[p]    = win_top_r;
      case (rg[p]) inside
        REG_LEFT, REG_UP_LEFT, REG_DOWN_LEFT: begin
          has_v[p] = 1'b1;
          ve[p]    = win_left_r;
        end
        REG_RIGHT, REG_UP_RIGHT, REG_DOWN_RIGHT: begin
          has_v[p] = 1'b1;
          ve[p]    = win_right_r;
        end
        default: ;
      endcase
      case (rg[p]) inside
        REG_UP, REG_UP_LEFT, REG_UP_RIGHT: begin
          has_h[p] = 1'b1;
          he[p]    = win_top_r;
        end
        REG_DOWN, REG_DOWN_LEFT, REG_DOWN_RIGHT: begin
          has_h[p] = 1'b1;
          he[p]    = win_bottom_r;
        end
        default: ;
      endcase
    end
  end

  // one lane per (endpoint, edge): 0 start vertical, 1 start horizontal,
  // 2 end vertical, 3 end horizontal
  always_comb begin
    coord_t                    a1, a2, b1, b2, e;
    logic                      has;
    logic signed [DIFF_W-1:0]  d, n, den;
    logic [DIFF_W-1:0]         md, mn, mden;
    side_nxt.seg   = in_r;
    side_nxt.reg_s = rg[0];
    side_nxt.reg_e = rg[1];
    side_nxt.ve_s  = ve[0];
    side_nxt.he_s  = he[0];
    side_nxt.ve_e  = ve[1];
    side_nxt.he_e  = he[1];
    for (int k = 0; k < 4; k++) begin
      if ((k % 2) == 0) begin
        a1  = in_r.start_x;
        a2  = in_r.end_x;
        b1  = in_r.start_y;
        b2  = in_r.end_y;
        e   = ve[k/2];
        has = has_v[k/2];
        side_nxt.erange[k] = (e >= win_left_r) && (e <= win_right_r);
      end else begin
        a1  = in_r.start_y;
        a2  = in_r.end_y;
        b1  = in_r.start_x;
        b2  = in_r.end_x;
        e   = he[k/2];
        has = has_h[k/2];
        side_nxt.erange[k] = (e >= win_bottom_r) && (e <= win_top_r);
      end
      d    = DIFF_W'(b2) - DIFF_W'(b1);
      n    = DIFF_W'(e) - DIFF_W'(a1);
      den  = DIFF_W'(a2) - DIFF_W'(a1);
      md   = mag(d);
      mn   = mag(n);
      mden = mag(den);
      side_nxt.en[k]  = has && (a1 != a2) &&
                        (((e >= a1) && (e <= a2)) || ((e >= a2) && (e <= a1)));
      side_nxt.neg[k] = d[DIFF_W-1] ^ n[DIFF_W-1] ^ den[DIFF_W-1];
      div_nxt[k].rem  = PROD_W'(md) * PROD_W'(mn);
      // parked lanes divide by one so the chain never sees zero
      div_nxt[k].den  = side_nxt.en[k] ? mden : DIFF_W'(1);
      div_nxt[k].quot = '0;
    end
  end

  side_t      side2_r;
  div_stage_t div_r [4];
  logic       v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    side2_r <= side_nxt;
    for (int k = 0; k < 4; k++) begin
      div_r[k] <= div_nxt[k];
    end
  end

  // stage 3: four division chains, sideband delay line alongside
  div_stage_t div_q [4];

  for (genvar k = 0; k < 4; k++) begin : g_lane
    swc_divider u_div (
      .clk (clk),
      .d_i (div_r[k]),
      .d_o (div_q[k])
    );
  end

  side_t side_line_r [DIFF_W];
  logic  v_line_r    [DIFF_W];

  always_ff @(posedge clk) begin
    side_line_r[0] <= side2_r;
    for (int i = 1; i < DIFF_W; i++) begin
      side_line_r[i] <= side_line_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIFF_W; i++) v_line_r[i] <= 1'b0;
    end else begin
      v_line_r[0] <= v2_r;
      for (int i = 1; i < DIFF_W; i++) v_line_r[i] <= v_line_r[i-1];
    end
  end

  // stage 4: rebuild intersections, pick candidates, form result
  side_t    sd;
  seg_out_t out_nxt;

  always_comb begin
    logic signed [EXT_W-1:0] qs, res [4];
    logic [3:0]              hit;
    coord_t                  b1;
    logic                    ok_s, ok_e;
    coord_t                  csx, csy, cex, cey;
    sd = side_line_r[DIFF_W-1];
    for (int k = 0; k < 4; k++) begin
      b1     = ((k % 2) == 0) ? sd.seg.start_y : sd.seg.start_x;
      qs     = $signed({1'b0, div_q[k].quot});
      res[k] = EXT_W'(b1) + (sd.neg[k] ? -qs : qs);
      if ((k % 2) == 0)
        hit[k] = sd.en[k] && sd.erange[k] &&
                 (res[k] >= EXT_W'(win_bottom_r)) && (res[k] <= EXT_W'(win_top_r));
      else
        hit[k] = sd.en[k] && sd.erange[k] &&
                 (res[k] >= EXT_W'(win_left_r)) && (res[k] <= EXT_W'(win_right_r));
    end

    // start point: keep when inside, else vertical edge first
    ok_s = 1'b1;
    csx  = sd.seg.start_x;
    csy  = sd.seg.start_y;
    if (sd.reg_s != REG_INSIDE) begin
      if (hit[0]) begin
        csx = sd.ve_s;
        csy = COORD_WIDTH'(res[0]);
      end else if (hit[1]) begin
        csx = COORD_WIDTH'(res[1]);
        csy = sd.he_s;
      end else begin
        ok_s = 1'b0;
      end
    end

    ok_e = 1'b1;
    cex  = sd.seg.end_x;
    cey  = sd.seg.end_y;
    if (sd.reg_e != REG_INSIDE) begin
      if (hit[2]) begin
        cex = sd.ve_e;
        cey = COORD_WIDTH'(res[2]);
      end else if (hit[3]) begin
        cex = COORD_WIDTH'(res[3]);
        cey = sd.he_e;
      end else begin
        ok_e = 1'b0;
      end
    end

    out_nxt.visible      = ok_s && ok_e;
    out_nxt.clip_start_x = out_nxt.visible ? csx : '0;
    out_nxt.clip_start_y = out_nxt.visible ? csy : '0;
    out_nxt.clip_end_x   = out_nxt.visible ? cex : '0;
    out_nxt.clip_end_y   = out_nxt.visible ? cey : '0;
    out_nxt.start_region = sd.reg_s;
    out_nxt.end_region   = sd.reg_e;
  end

  // output register, strobe lasts one cycle per transaction
  logic     out_strobe_r;
  seg_out_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe_r <= 1'b0;
    else        out_strobe_r <= v_line_r[DIFF_W-1];
    out_item_r <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

@@ hdl/swc_checker.sv @@
// port level checks of the segment window clipper and their bind
module swc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input swc_pkg::seg_in_t   in_item,
  input logic               out_strobe,
  input swc_pkg::seg_out_t  out_item
);
  import swc_pkg::*;

  // reset silences the result strobe
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

  // every transaction returns after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(LATENCY) out_strobe)
    else $error("transaction result missing");

  // no result without a transaction behind it
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, LATENCY))
    else $error("result without transaction");

  // hidden segments report zero coordinates
  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.visible) |->
      (out_item.clip_start_x == '0 && out_item.clip_start_y == '0 &&
       out_item.clip_end_x == '0 && out_item.clip_end_y == '0))
    else $error("hidden segment with nonzero coordinates");

  // an inside start point comes back unchanged
  a_inside_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.visible && out_item.start_region == REG_INSIDE) |->
      (out_item.clip_start_x == $past(in_item.start_x, LATENCY) &&
       out_item.clip_start_y == $past(in_item.start_y, LATENCY)))
    else $error("inside start point altered");

endmodule

bind segment_window_clipper swc_checker u_swc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_item    (in_item),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

@@ dv/testbench.sv @@
// testbench of the segment window clipper: directed table, random segments, predictor
`timescale 1ns / 1ps

module testbench;
  import swc_pkg::*;

  localparam int  LIMIT_CYCLES = 400000;
  localparam int  N_RANDOM     = 1930;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  seg_in_t   in_item = '0;
  logic      out_strobe;
  seg_out_t  out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0] cfg_index = '0;
  coord_t    cfg_data = '0;

  segment_window_clipper dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // predictor's copy of the window
  coord_t win_l, win_r, win_b, win_t;

  // clipped results still owed by the block, oldest first
  seg_out_t clip_queue[$];
  int       n_errors = 0;
  int       n_results = 0;
  int       n_visible = 0;
  int       cycle = 0;
  int       send_idle_pct = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s: got %0d expected %0d (result %0d)", what, got, want, n_results);
    n_errors++;
  endtask

  // b1 + (b2 - b1) * (e - a1) / (a2 - a1), truncated toward zero
  function automatic longint lerp_edge(longint a1, longint b1, longint a2, longint b2,
                                       longint e);
    longint d, n, den, q;
    d = b2 - b1;
    n = e - a1;
    den = a2 - a1;
    q = ((d < 0 ? -d : d) * (n < 0 ? -n : n)) / (den < 0 ? -den : den);
    if (n == 0 || d == 0) return b1;
    return (((d < 0) != (n < 0)) != (den < 0)) ? b1 - q : b1 + q;
  endfunction

  function automatic logic [3:0] zone_of(longint x, longint y);
    longint l, r, b, t;
    l = win_l; r = win_r; b = win_b; t = win_t;
    if (x > l && x < r && y > b && y < t) return REG_INSIDE;
    if (x <= l && y >= t) return REG_UP_LEFT;
    if (x >= r && y >= t) return REG_UP_RIGHT;
    if (x <= l && y <= b) return REG_DOWN_LEFT;
    if (x >= r && y <= b) return REG_DOWN_RIGHT;
    if (y >= t) return REG_UP;
    if (y <= b) return REG_DOWN;
    if (x >= r) return REG_RIGHT;
    return REG_LEFT;
  endfunction

  // moves one endpoint onto the window; returns 0 when no edge qualifies
  function automatic bit clip_end(input logic [3:0] zone, input longint px, input longint py,
                                  input seg_in_t s, output longint cx, output longint cy);
    longint x1, y1, x2, y2, l, r, b, t, ve, he, v;
    bit hv, hh;
    x1 = s.start_x; y1 = s.start_y; x2 = s.end_x; y2 = s.end_y;
    l = win_l; r = win_r; b = win_b; t = win_t;
    hv = 0; hh = 0; ve = 0; he = 0; cx = 0; cy = 0;
    if (zone == REG_INSIDE) begin
      cx = px; cy = py;
      return 1;
    end
    if (zone == REG_LEFT || zone == REG_UP_LEFT || zone == REG_DOWN_LEFT) begin
      hv = 1; ve = l;
    end
    if (zone == REG_RIGHT || zone == REG_UP_RIGHT || zone == REG_DOWN_RIGHT) begin
      hv = 1; ve = r;
    end
    if (zone == REG_UP || zone == REG_UP_LEFT || zone == REG_UP_RIGHT) begin
      hh = 1; he = t;
    end
    if (zone == REG_DOWN || zone == REG_DOWN_LEFT || zone == REG_DOWN_RIGHT) begin
      hh = 1; he = b;
    end
    // vertical edge first, skipped when parallel or off the segment
    if (hv && x1 != x2 && ve >= (x1 < x2 ? x1 : x2) && ve <= (x1 < x2 ? x2 : x1)) begin
      v = lerp_edge(x1, y1, x2, y2, ve);
      if (ve >= l && ve <= r && v >= b && v <= t) begin
        cx = ve; cy = v;
        return 1;
      end
    end
    if (hh && y1 != y2 && he >= (y1 < y2 ? y1 : y2) && he <= (y1 < y2 ? y2 : y1)) begin
      v = lerp_edge(y1, x1, y2, x2, he);
      if (v >= l && v <= r && he >= b && he <= t) begin
        cx = v; cy = he;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic seg_out_t clip_segment(seg_in_t s);
    seg_out_t o;
    longint ax, ay, bx, by;
    bit ok1, ok2;
    o.start_region = zone_of(s.start_x, s.start_y);
    o.end_region   = zone_of(s.end_x, s.end_y);
    ok1 = clip_end(o.start_region, s.start_x, s.start_y, s, ax, ay);
    ok2 = clip_end(o.end_region, s.end_x, s.end_y, s, bx, by);
    o.visible = ok1 && ok2;
    if (!o.visible) begin
      ax = 0; ay = 0; bx = 0; by = 0;
    end
    o.clip_start_x = coord_t'(ax);
    o.clip_start_y = coord_t'(ay);
    o.clip_end_x   = coord_t'(bx);
    o.clip_end_y   = coord_t'(by);
    return o;
  endfunction

  // result checker: every strobe consumes the oldest expectation
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (rst_n && out_strobe) begin
      if (clip_queue.size() == 0) begin
        $display("result with nothing expected");
        n_errors++;
      end else begin
        seg_out_t w;
        w = clip_queue.pop_front();
        if (out_item.visible !== w.visible)
          report_mismatch("visible", out_item.visible, w.visible);
        if (out_item.clip_start_x !== w.clip_start_x)
          report_mismatch("clip_start_x", out_item.clip_start_x, w.clip_start_x);
        if (out_item.clip_start_y !== w.clip_start_y)
          report_mismatch("clip_start_y", out_item.clip_start_y, w.clip_start_y);
        if (out_item.clip_end_x !== w.clip_end_x)
          report_mismatch("clip_end_x", out_item.clip_end_x, w.clip_end_x);
        if (out_item.clip_end_y !== w.clip_end_y)
          report_mismatch("clip_end_y", out_item.clip_end_y, w.clip_end_y);
        if (out_item.start_region !== w.start_region)
          report_mismatch("start_region", out_item.start_region, w.start_region);
        if (out_item.end_region !== w.end_region)
          report_mismatch("end_region", out_item.end_region, w.end_region);
        if (w.visible) n_visible++;
      end
      n_results++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycle > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle);
      $display("FAILURE");
      $finish;
    end
  end

  // one register write through the config channel; block must be idle
  task automatic write_window(input logic [1:0] idx, input coord_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_LEFT:   win_l = val;
      CFG_RIGHT:  win_r = val;
      CFG_BOTTOM: win_b = val;
      default:    win_t = val;
    endcase
  endtask

  task automatic set_window(input coord_t l, input coord_t r, input coord_t b, input coord_t t);
    write_window(CFG_LEFT, l);
    write_window(CFG_RIGHT, r);
    write_window(CFG_BOTTOM, b);
    write_window(CFG_TOP, t);
    cfg_valid <= 1'b0;
  endtask

  // wait for all results, then let the pipeline run empty
  task automatic drain_pipe();
    while (clip_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // send one segment; sender gaps drawn from send_idle_pct
  task automatic send_segment(input seg_in_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    clip_queue.push_back(clip_segment(s));
  endtask

  // random point near the window edges, inside, or anywhere
  function automatic coord_t pick_coord(coord_t lo, coord_t hi);
    int k;
    k = $urandom_range(9);
    if (k < 3) return coord_t'($urandom());
    if (k < 5) return coord_t'(longint'(lo) + $urandom_range(4) - 2);
    if (k < 7) return coord_t'(longint'(hi) + $urandom_range(4) - 2);
    return coord_t'(longint'(lo) + longint'($urandom_range(32'(longint'(hi) - lo + 200)))
                    - 100);
  endfunction

  function automatic seg_in_t rand_segment();
    seg_in_t s;
    s.start_x = pick_coord(win_l, win_r);
    s.start_y = pick_coord(win_b, win_t);
    s.end_x   = pick_coord(win_l, win_r);
    s.end_y   = pick_coord(win_b, win_t);
    // axis-parallel segments now and then
    case ($urandom_range(9))
      0: s.end_x = s.start_x;
      1: s.end_y = s.start_y;
      default: ;
    endcase
    return s;
  endfunction

  typedef struct {
    seg_in_t  seg;
    bit       known;
    seg_out_t want;
  } stim_row_t;

  stim_row_t rows[$];

  function automatic stim_row_t row(int x1, int y1, int x2, int y2);
    stim_row_t r;
    r.seg = '{coord_t'(x1), coord_t'(y1), coord_t'(x2), coord_t'(y2)};
    r.known = 0;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t row_k(int x1, int y1, int x2, int y2, seg_out_t w);
    stim_row_t r;
    r = row(x1, y1, x2, y2);
    r.known = 1;
    r.want = w;
    return r;
  endfunction

  initial begin
    int p;
    stim_row_t r;
    seg_out_t pr;
    win_l = 0; win_r = 639; win_b = 0; win_t = 479;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table against the reset window
    rows.push_back(row_k(10, 10, 20, 20, '{1'b1, 10, 10, 20, 20, REG_INSIDE, REG_INSIDE}));
    rows.push_back(row_k(-32768, -32768, -32768, 32767,
                         '{1'b0, 0, 0, 0, 0, REG_DOWN_LEFT, REG_UP_LEFT}));
    rows.push_back(row_k(32767, 32767, 32767, -32768,
                         '{1'b0, 0, 0, 0, 0, REG_UP_RIGHT, REG_DOWN_RIGHT}));
    rows.push_back(row(-100, 200, 700, 200));     // left to right, horizontal
    rows.push_back(row(300, -50, 300, 600));      // vertical through window
    rows.push_back(row(-100, -100, 700, 579));    // corner to corner
    rows.push_back(row(-10, -10, 10, 10));        // hits the window corner
    rows.push_back(row(-10, 500, 100, 400));      // up-left entry
    rows.push_back(row(650, 500, 500, 300));      // up-right
    rows.push_back(row(650, -20, 600, 100));      // down-right
    rows.push_back(row(100, 500, 200, 300));      // up
    rows.push_back(row(100, -5, 200, 300));       // down
    rows.push_back(row(700, 100, 300, 100));      // right
    rows.push_back(row(-50, 100, 50, 100));       // left
    rows.push_back(row(-50, 100, -10, 900));      // misses entirely
    rows.push_back(row(0, 0, 639, 479));          // on the edges
    rows.push_back(row(-32768, 32767, 32767, -32768));
    rows.push_back(row(700, 600, 700, 600));      // single point outside
    foreach (rows[i]) begin
      send_segment(rows[i].seg);
      if (rows[i].known) begin
        pr = clip_queue[$];
        if (pr != rows[i].want) begin
          $display("table row %0d disagrees with predictor", i);
          n_errors++;
        end
      end
    end
    start <= 1'b0;
    drain_pipe();

    // random phases over several windows, extremes included
    for (p = 0; p < 6; p++) begin
      case (p)
        0: set_window(-32768, 32767, -32768, 32767);
        1: set_window(-200, 200, -100, 100);
        2: set_window(100, 50, 30, 10);           // degenerate window
        3: set_window(-32768, -32000, 32000, 32767);
        4: set_window(coord_t'($urandom()), coord_t'($urandom()),
                      coord_t'($urandom()), coord_t'($urandom()));
        default: set_window(0, 639, 0, 479);
      endcase
      send_idle_pct = (p < 2) ? 35 : (p < 4) ? 79 : 0;
      repeat (N_RANDOM / 6) begin
        send_segment(rand_segment());
        // hold off about once per phase, at random, until the pipe empties
        if ($urandom_range(N_RANDOM / 6) == 0) begin
          start <= 1'b0;
          while (clip_queue.size() != 0) @(posedge clk);
        end
      end
      start <= 1'b0;
      drain_pipe();
    end

    $display("checked %0d clip results, %0d visible, over 7 window settings",
             n_results, n_visible);
    if (n_errors == 0 && clip_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, clip_queue.size());
      $display("FAILURE");
    end
    $finish;
  end
endmodule
